/* rtl/first_fit_heap_allocator_core_defines.svh */
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
// assert that a implies b at the same edge
`define FFH_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// assert that a implies b at the next edge
`define FFH_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

/* rtl/ffh_pkg.sv */
// shared types and constants of the heap allocator
package ffh_pkg;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEAP_UNITS_DEF = 65536;
  localparam int UNIT_BYTES_DEF = 32;
  localparam int ADDR_W = 21;
  localparam int GROW_W = 17;
  localparam logic [GROW_W-1:0] GROW_RESET = 17'd2048;
  localparam logic [ADDR_W-1:0] ADDR_MAX = 21'h1FFFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // byte address of the grow_min_units register
  localparam logic [1:0] REG_GROW = 2'd0;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_APPEND, S_SPLIT_CHK,
    S_SH_UP_RD, S_SH_UP_WR, S_SPLIT_WR, S_MARK, S_DONE,
    S_MN_RD0, S_MN_RD1, S_MN_CHK, S_SH_DN_RD, S_SH_DN_WR,
    S_MP_PREP, S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cap_req;
    logic idx_clr;
    logic idx_inc;
    logic idx_dec;
    logic idx_from_cnt;
    logic idx_from_hit;
    logic idx_from_base;
    logic rd_idx;
    logic rd_idx_m1;
    logic rd_idx_p1;
    logic wr_append;
    logic wr_shift_up;
    logic wr_split_hi;
    logic wr_split_lo;
    logic wr_mark_used;
    logic wr_free;
    logic wr_merged;
    logic wr_shift_dn;
    logic cnt_inc;
    logic cnt_dec;
    logic hit_save;
    logic base_save_m1;
    logic sav_a;
    logic res_ok_addr;
    logic res_oom;
    logic res_bad;
    logic res_ok0;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic free_zero;
    logic idx_at_cnt;
    logic idx_last;
    logic fit;
    logic match;
    logic table_full;
    logic append_ok;
    logic split_ok;
    logic both_free;
    logic idx_zero;
    logic idx_at_split;
  } stat_t;
endpackage

/* rtl/ffh_if.sv */
// valid/ready channel interfaces
interface ffh_req_if;
  logic valid;
  logic ready;
  logic command;
  logic [31:0] req_size;
  logic [20:0] free_addr;
  modport source (output valid, command, req_size, free_addr, input ready);
  modport sink (input valid, command, req_size, free_addr, output ready);
endinterface

interface ffh_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [20:0] payload_addr;
  modport source (output valid, status, payload_addr, input ready);
  modport sink (input valid, status, payload_addr, output ready);
endinterface

/* rtl/ffh_ram.sv */
// generic single-port ram with registered read
module ffh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/ffh_datapath.sv */
// segment table, counters and arithmetic of the allocator
module ffh_datapath #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEAP_UNITS = 65536,
  parameter int UNIT_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ffh_pkg::cmd_t     cmd,
  output ffh_pkg::stat_t    stat,
  input  logic              req_command,
  input  logic [31:0]       req_size,
  input  logic [20:0]       free_addr,
  input  logic [16:0]       grow_min,
  output logic [1:0]        res_status,
  output logic [20:0]       res_addr
);
  import ffh_pkg::*;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UW = $clog2(HEAP_UNITS + 1);
  localparam int SW = $clog2(HEAP_UNITS);
  localparam int UB = $clog2(UNIT_BYTES);
  localparam int ENTW = SW + UW + 1;
  localparam int NW = 33 - UB + 1;

  logic [CW-1:0] cnt;
  logic [UW-1:0] top;
  logic [IW:0]   idx, hit, base;
  logic          cmd_q;
  logic [NW-1:0] need;
  logic [20:0]   faddr;
  logic [ENTW-1:0] ram_wd, ram_rd, sav;
  logic          ram_we;
  logic [IW-1:0] ram_a;
  logic [IW:0]   ra;

  logic [SW-1:0] r_start;
  logic [UW-1:0] r_size;
  logic          r_used;
  assign {r_start, r_size, r_used} = ram_rd;
  logic [SW-1:0] s_start;
  logic [UW-1:0] s_size;
  logic          s_used;
  assign {s_start, s_size, s_used} = sav;

  // payload address of a start unit, wide enough to test the 21-bit limit
  logic [SW+UB:0] pay_r, pay_top;
  assign pay_r = ({1'b0, r_start} + {{SW{1'b0}}, 1'b1}) << UB;
  assign pay_top = ({1'b0, top[SW-1:0]} + {{SW{1'b0}}, 1'b1}) << UB;
  logic pay_r_ok, pay_top_ok;
  assign pay_r_ok = (pay_r <= (SW+UB+1)'(ADDR_MAX));
  assign pay_top_ok = (pay_top <= (SW+UB+1)'(ADDR_MAX)) && top < UW'(HEAP_UNITS);

  logic [NW-1:0] grow;
  assign grow = (need < NW'(grow_min)) ? NW'(grow_min) : need;
  logic [NW:0] top_sum;
  assign top_sum = {1'b0, grow} + (NW+1)'(top);

  always_comb begin
    ra = idx;
    if (cmd.rd_idx_m1) ra = idx - 1'b1;
    if (cmd.rd_idx_p1) ra = idx + 1'b1;
  end

  always_comb begin
    ram_we = 1'b1;
    ram_a = ra[IW-1:0];
    ram_wd = ram_rd;
    if (cmd.wr_append) begin
      ram_a = idx[IW-1:0];
      ram_wd = {top[SW-1:0], UW'(grow), 1'b0};
    end else if (cmd.wr_shift_up || cmd.wr_shift_dn) begin
      // the neighbor read on the previous cycle moves into idx
      ram_a = idx[IW-1:0];
      ram_wd = ram_rd;
    end else if (cmd.wr_split_hi) begin
      ram_a = IW'(hit + 1'b1);
      ram_wd = {SW'(s_start + SW'(need)), UW'(s_size - UW'(need)), 1'b0};
    end else if (cmd.wr_split_lo) begin
      ram_a = hit[IW-1:0];
      ram_wd = {s_start, UW'(need), 1'b1};
    end else if (cmd.wr_mark_used) begin
      ram_a = hit[IW-1:0];
      ram_wd = {s_start, s_size, 1'b1};
    end else if (cmd.wr_free) begin
      ram_a = hit[IW-1:0];
      ram_wd = {s_start, s_size, 1'b0};
    end else if (cmd.wr_merged) begin
      ram_a = base[IW-1:0];
      ram_wd = {s_start, UW'(s_size + r_size), 1'b0};
    end else begin
      ram_we = 1'b0;
    end
  end

  ffh_ram #(.WIDTH(ENTW), .DEPTH(MAX_SEGMENTS)) u_tab (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      top <= '0;
    end else begin
      if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      if (cmd.cnt_dec) cnt <= cnt - 1'b1;
      if (cmd.wr_append) top <= UW'(top_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      cmd_q <= req_command;
      need <= NW'(({2'b0, req_size} + 34'(2*UNIT_BYTES - 1)) >> UB);
      faddr <= free_addr;
    end
    if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
    else if (cmd.idx_dec) idx <= idx - 1'b1;
    else if (cmd.idx_from_cnt) idx <= (IW+1)'(cnt);
    else if (cmd.idx_from_hit) idx <= hit;
    else if (cmd.idx_from_base) idx <= hit - 1'b1; // same entry that base_save_m1 picks
    if (cmd.hit_save) hit <= idx;
    if (cmd.base_save_m1) base <= hit - 1'b1;
    else if (cmd.idx_from_hit) base <= hit;
    if (cmd.sav_a) sav <= ram_rd;
    if (cmd.res_ok_addr) begin
      res_status <= ST_OK;
      res_addr <= 21'(({5'b0, s_start} + 21'd1) << UB);
    end
    if (cmd.res_oom || cmd.res_bad || cmd.res_ok0) begin
      res_status <= cmd.res_oom ? ST_OOM : (cmd.res_bad ? ST_BADFREE : ST_OK);
      res_addr <= '0;
    end
  end

  assign stat.is_free = (cmd_q == CMD_FREE);
  assign stat.free_zero = (faddr == '0);
  assign stat.idx_at_cnt = (idx == (IW+1)'(cnt));
  assign stat.idx_last = ((idx + 1'b1) >= (IW+1)'(cnt));
  assign stat.fit = !r_used && ({{(NW-UW){1'b0}}, r_size} >= need) && pay_r_ok;
  assign stat.match = r_used && (pay_r == (SW+UB+1)'(faddr));
  assign stat.table_full = (cnt == CW'(MAX_SEGMENTS));
  assign stat.append_ok = (top_sum <= (NW+1)'(HEAP_UNITS)) && pay_top_ok;
  assign stat.split_ok = ((s_size - UW'(need)) >= UW'(2)) &&
                         (cnt != CW'(MAX_SEGMENTS));
  assign stat.both_free = !s_used && !r_used;
  assign stat.idx_zero = (hit == '0);
  assign stat.idx_at_split = (idx == hit + 1'b1);
endmodule

/* rtl/ffh_ctrl.sv */
// controller state machine of the allocator
module ffh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ffh_pkg::cmd_t  cmd,
  input  ffh_pkg::stat_t stat
);
  import ffh_pkg::*;
  `include "first_fit_heap_allocator_core_defines.svh"
  state_t state, state_next;
  logic ov, ov_next;
  logic prev, prev_next; // second merge pending

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
      prev <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      prev <= prev_next;
    end
  end
  assign out_valid = ov;

  always_comb begin
    state_next = state;
    prev_next = prev;
    cmd = '0;
    ov_next = ov && !out_ready;
    in_ready = (state == S_IDLE) && (!ov || out_ready);
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap_req = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat.idx_at_cnt) begin
          if (stat.is_free) begin
            cmd.res_bad = !stat.free_zero;
            cmd.res_ok0 = stat.free_zero;
            state_next = S_RESULT;
          end else state_next = S_APPEND;
        end else if (stat.is_free && stat.free_zero) begin
          cmd.res_ok0 = 1'b1;
          state_next = S_RESULT;
        end else state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd.hit_save = 1'b1;
        cmd.sav_a = 1'b1;
        if (stat.is_free ? stat.match : stat.fit) begin
          state_next = stat.is_free ? S_MARK : S_SPLIT_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        if (stat.table_full || !stat.append_ok) begin
          cmd.res_oom = 1'b1;
          state_next = S_RESULT;
        end else begin
          // re-read the new entry so the check sees it
          cmd.wr_append = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.hit_save = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SPLIT_CHK: begin
        if (stat.split_ok) begin
          cmd.idx_from_cnt = 1'b1;
          state_next = S_SH_UP_RD;
        end else state_next = S_MARK;
      end
      S_SH_UP_RD: begin
        // move entries idx-1 to idx until idx reaches hit+1
        if (stat.idx_at_split) state_next = S_SPLIT_WR;
        else begin
          cmd.rd_idx_m1 = 1'b1;
          state_next = S_SH_UP_WR;
        end
      end
      S_SH_UP_WR: begin
        cmd.wr_shift_up = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next = S_SH_UP_RD;
      end
      S_SPLIT_WR: begin
        cmd.wr_split_hi = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = S_DONE;
      end
      S_MARK: begin
        if (stat.is_free) begin
          cmd.wr_free = 1'b1;
          cmd.idx_from_hit = 1'b1;
          prev_next = !stat.idx_zero;
          state_next = S_MN_RD0;
        end else begin
          cmd.wr_mark_used = 1'b1;
          cmd.res_ok_addr = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_DONE: begin
        cmd.wr_split_lo = 1'b1;
        cmd.res_ok_addr = 1'b1;
        state_next = S_RESULT;
      end
      S_MN_RD0: begin
        cmd.rd_idx = 1'b1;
        state_next = S_MN_RD1;
      end
      S_MN_RD1: begin
        cmd.sav_a = 1'b1;
        if (stat.idx_last) state_next = S_MP_PREP;
        else begin
          cmd.rd_idx_p1 = 1'b1;
          state_next = S_MN_CHK;
        end
      end
      S_MN_CHK: begin
        if (stat.both_free) begin
          cmd.wr_merged = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next = S_SH_DN_RD;
        end else state_next = S_MP_PREP;
      end
      S_SH_DN_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_MP_PREP;
        end else begin
          cmd.rd_idx_p1 = 1'b1;
          state_next = S_SH_DN_WR;
        end
      end
      S_SH_DN_WR: begin
        cmd.wr_shift_dn = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_SH_DN_RD;
      end
      S_MP_PREP: begin
        if (prev) begin
          prev_next = 1'b0;
          cmd.base_save_m1 = 1'b1;
          cmd.idx_from_base = 1'b1;
          state_next = S_MN_RD0;
        end else begin
          cmd.res_ok0 = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        ov_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `FFH_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")
  `FFH_ASSERT_NEXT(a_result_valid, clk, rst, state == S_RESULT, ov, "result not shown")
  `FFH_ASSERT_NEXT(a_hold, clk, rst, ov && !out_ready, ov, "result dropped")
endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// first-fit heap allocator: top level with config port
// an item takes longer for each segment searched and each entry shifted on a split or merge
// throughput: one item at a time; the next item is taken once the result is accepted
// reset: synchronous active high; clears segment count, heap top, grow register
// to 2048 and the handshake state; table contents stay undefined
module first_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = ffh_pkg::MAX_SEGMENTS_DEF,
  parameter int HEAP_UNITS = ffh_pkg::HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = ffh_pkg::UNIT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ffh_req_if.sink     req,
  ffh_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffh_pkg::*;
  logic [16:0] grow_min;
  cmd_t cmd;
  stat_t stat;

  // config register: grow_min_units at address 0
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) grow_min <= GROW_RESET;
    else if (psel && penable && pwrite && paddr == REG_GROW)
      grow_min <= pwdata[16:0];
  end
  assign prdata = (paddr == REG_GROW) ? {15'b0, grow_min} : 32'b0;

  ffh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  ffh_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS), .HEAP_UNITS(HEAP_UNITS), .UNIT_BYTES(UNIT_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_command(req.command), .req_size(req.req_size), .free_addr(req.free_addr),
    .grow_min(grow_min),
    .res_status(rsp.status), .res_addr(rsp.payload_addr)
  );
endmodule
